FILE: design/i2cbm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`default_nettype none
package i2cbm_pkg;

   // command kinds carried by an input transaction
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // configuration register indexes
   localparam logic CSR_HALF_PERIOD   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   localparam logic [15:0] HALF_PERIOD_RESET   = 16'd5;
   localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd10000;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_seen;
      logic [7:0] rx_byte;
      logic       bus_error;
   } result_type;

endpackage
`default_nettype wire

FILE: design/i2cbm_engine.sv
// Phase sequencer of the I2C master bit engine: one step per accepted tick.
`default_nettype none
module i2cbm_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [2:0]           kind,
   input  wire logic [7:0]           tx_byte,
   input  wire logic                 send_nack,
   input  wire logic                 scl_in,
   input  wire logic                 sda_in,
   input  wire logic [15:0]          half_period,
   input  wire logic [15:0]          stretch_limit,
   output i2cbm_pkg::result_type     result
);

   localparam logic [4:0] PH_IDLE = 5'd0;
   localparam logic [4:0] PH_S_D1 = 5'd1;
   localparam logic [4:0] PH_S_W  = 5'd2;
   localparam logic [4:0] PH_S_D2 = 5'd3;
   localparam logic [4:0] PH_S_D3 = 5'd4;
   localparam logic [4:0] PH_P_D1 = 5'd5;
   localparam logic [4:0] PH_P_D2 = 5'd6;
   localparam logic [4:0] PH_P_W  = 5'd7;
   localparam logic [4:0] PH_P_D3 = 5'd8;
   localparam logic [4:0] PH_P_D4 = 5'd9;
   localparam logic [4:0] PH_W_D0 = 5'd10;
   localparam logic [4:0] PH_W_DL = 5'd11;
   localparam logic [4:0] PH_W_W  = 5'd12;
   localparam logic [4:0] PH_W_DH = 5'd13;
   localparam logic [4:0] PH_A_DL = 5'd14;
   localparam logic [4:0] PH_A_W  = 5'd15;
   localparam logic [4:0] PH_A_DH = 5'd16;
   localparam logic [4:0] PH_A_DS = 5'd17;
   localparam logic [4:0] PH_R_D0 = 5'd18;
   localparam logic [4:0] PH_R_DL = 5'd19;
   localparam logic [4:0] PH_R_W  = 5'd20;
   localparam logic [4:0] PH_R_DH = 5'd21;
   localparam logic [4:0] PH_K_D1 = 5'd22;
   localparam logic [4:0] PH_K_D2 = 5'd23;
   localparam logic [4:0] PH_K_W  = 5'd24;
   localparam logic [4:0] PH_K_DH = 5'd25;

   // line drive bits, status flag bits
   localparam int DRV_SCL = 0;
   localparam int DRV_SDA = 1;
   localparam int FL_ACK  = 0;
   localparam int FL_ERR  = 1;
   localparam int FL_NACK = 2;

   logic [4:0]  phase_ff,   phase_in;
   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  shift_ff,   shift_in;
   logic [15:0] delay_ff,   delay_in;
   logic [15:0] stretch_ff, stretch_in;
   logic [1:0]  drive_ff,   drive_in;
   logic [2:0]  flags_ff,   flags_in;
   logic [7:0]  rx_hold_ff, rx_hold_in;

   logic [15:0] hp, lim;
   logic [15:0] dly_inc, dly_next, st_inc, st_next;
   logic        dly_over, st_timeout;
   logic [3:0]  bit_dec;
   logic [7:0]  shift_rx;
   logic        done;

   // zero in either register acts as one
   assign hp  = (half_period == 16'd0)   ? 16'd1 : half_period;
   assign lim = (stretch_limit == 16'd0) ? 16'd1 : stretch_limit;

   assign dly_inc    = delay_ff + 16'd1;
   assign dly_over   = dly_inc >= hp;
   assign dly_next   = dly_over ? 16'd0 : dly_inc;
   assign st_inc     = stretch_ff + 16'd1;
   assign st_timeout = !scl_in && (st_inc >= lim);
   assign st_next    = (scl_in || st_timeout) ? 16'd0 : st_inc;
   assign bit_dec    = bit_idx_ff - 4'd1;
   assign shift_rx   = {shift_ff[6:0], sda_in};

   always_comb begin
      phase_in   = phase_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      delay_in   = delay_ff;
      stretch_in = stretch_ff;
      drive_in   = drive_ff;
      flags_in   = flags_ff;
      rx_hold_in = rx_hold_ff;
      done       = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (kind inside {i2cbm_pkg::KIND_START, i2cbm_pkg::KIND_STOP,
                             i2cbm_pkg::KIND_WRITE, i2cbm_pkg::KIND_READ}) begin
               flags_in[FL_ERR]  = 1'b0;
               flags_in[FL_NACK] = 1'b0;
               delay_in   = 16'd0;
               stretch_in = 16'd0;
               case (kind)
                  i2cbm_pkg::KIND_START: begin
                     drive_in[DRV_SDA] = 1'b0;
                     phase_in = PH_S_D1;
                  end
                  i2cbm_pkg::KIND_STOP: begin
                     phase_in = PH_P_D1;
                  end
                  i2cbm_pkg::KIND_WRITE: begin
                     shift_in = tx_byte;
                     flags_in[FL_ACK] = 1'b0;
                     phase_in = PH_W_D0;
                  end
                  default: begin
                     shift_in = 8'd0;
                     flags_in[FL_NACK] = send_nack;
                     phase_in = PH_R_D0;
                  end
               endcase
            end
         end
         // delay phases that end by releasing SCL
         PH_S_D1, PH_P_D2, PH_W_DL, PH_A_DL, PH_R_DL, PH_K_D2: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SCL] = 1'b0;
               stretch_in = 16'd0;
               case (phase_ff)
                  PH_S_D1: phase_in = PH_S_W;
                  PH_P_D2: phase_in = PH_P_W;
                  PH_W_DL: phase_in = PH_W_W;
                  PH_A_DL: phase_in = PH_A_W;
                  PH_R_DL: phase_in = PH_R_W;
                  default: phase_in = PH_K_W;
               endcase
            end
         end
         // clock release waits; a timeout falls into the stop sequence
         PH_S_W, PH_W_W, PH_A_W, PH_R_W, PH_K_W: begin
            stretch_in = st_next;
            if (scl_in) begin
               case (phase_ff)
                  PH_S_W:  phase_in = PH_S_D2;
                  PH_W_W:  phase_in = PH_W_DH;
                  PH_A_W:  phase_in = PH_A_DH;
                  PH_R_W:  phase_in = PH_R_DH;
                  default: phase_in = PH_K_DH;
               endcase
            end else if (st_timeout) begin
               flags_in[FL_ERR] = 1'b1;
               phase_in = PH_P_D1;
               delay_in = 16'd0;
            end
         end
         PH_S_D2: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SDA] = 1'b1;
               phase_in = PH_S_D3;
            end
         end
         PH_S_D3, PH_P_D4: begin
            delay_in = dly_next;
            done = dly_over;
         end
         PH_P_D1: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SDA] = 1'b1;
               phase_in = PH_P_D2;
            end
         end
         PH_P_W: begin
            // inside a stop a timeout only flags and moves on
            stretch_in = st_next;
            if (st_timeout) flags_in[FL_ERR] = 1'b1;
            if (scl_in || st_timeout) phase_in = PH_P_D3;
         end
         PH_P_D3: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SDA] = 1'b0;
               phase_in = PH_P_D4;
            end
         end
         PH_W_D0: begin
            delay_in = dly_next;
            if (dly_over) begin
               bit_idx_in = 4'd7;
               drive_in[DRV_SCL] = 1'b1;
               drive_in[DRV_SDA] = ~shift_ff[7];
               phase_in = PH_W_DL;
            end
         end
         PH_W_DH: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SCL] = 1'b1;
               if (bit_idx_ff != 4'd0) begin
                  bit_idx_in = bit_dec;
                  drive_in[DRV_SDA] = ~shift_ff[bit_dec[2:0]];
                  phase_in = PH_W_DL;
               end else begin
                  drive_in[DRV_SDA] = 1'b0;
                  phase_in = PH_A_DL;
               end
            end
         end
         PH_A_DH: begin
            delay_in = dly_next;
            if (dly_over) begin
               flags_in[FL_ACK] = ~sda_in;
               phase_in = PH_A_DS;
            end
         end
         PH_A_DS: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SCL] = 1'b1;
               done = 1'b1;
            end
         end
         PH_R_D0: begin
            delay_in = dly_next;
            if (dly_over) begin
               bit_idx_in = 4'd8;
               drive_in[DRV_SCL] = 1'b1;
               phase_in = PH_R_DL;
            end
         end
         PH_R_DH: begin
            delay_in = dly_next;
            if (dly_over) begin
               shift_in   = shift_rx;
               bit_idx_in = bit_dec;
               drive_in[DRV_SCL] = 1'b1;
               if (bit_dec == 4'd0) begin
                  rx_hold_in = shift_rx;
                  phase_in = PH_K_D1;
               end else begin
                  phase_in = PH_R_DL;
               end
            end
         end
         PH_K_D1: begin
            delay_in = dly_next;
            if (dly_over) begin
               if (!flags_ff[FL_NACK]) drive_in[DRV_SDA] = 1'b1;
               phase_in = PH_K_D2;
            end
         end
         PH_K_DH: begin
            delay_in = dly_next;
            if (dly_over) begin
               drive_in[DRV_SCL] = 1'b1;
               drive_in[DRV_SDA] = 1'b0;
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (done) begin
         phase_in   = PH_IDLE;
         delay_in   = 16'd0;
         stretch_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= 4'd0;
         shift_ff   <= 8'd0;
         delay_ff   <= 16'd0;
         stretch_ff <= 16'd0;
         drive_ff   <= 2'b00;
         flags_ff   <= 3'b000;
         rx_hold_ff <= 8'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         delay_ff   <= delay_in;
         stretch_ff <= stretch_in;
         drive_ff   <= drive_in;
         flags_ff   <= flags_in;
         rx_hold_ff <= rx_hold_in;
      end
   end

   assign result.scl_pull_low = drive_in[DRV_SCL];
   assign result.sda_pull_low = drive_in[DRV_SDA];
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.done_res     = done;
   assign result.ack_seen     = flags_in[FL_ACK];
   assign result.rx_byte      = rx_hold_in;
   assign result.bus_error    = flags_in[FL_ERR];

`ifndef NO_ASSERTIONS
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && done) |=> (phase_ff == PH_IDLE))
      else $error("done pulse did not return the sequencer to idle");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (delay_ff == 16'd0 && stretch_ff == 16'd0))
      else $error("delay or stretch counter left running in idle");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      (bit_idx_ff <= 4'd8))
      else $error("bit index out of range");
`endif

endmodule
`default_nettype wire

FILE: design/i2c_bit_level_master_core.sv
// Top level of the I2C master bit engine: config registers and result register.
//
// Usage:
//  - Request channel (req_*): one transaction per time tick, carrying the
//    sampled SCL/SDA levels and a command kind (tick, start, stop, write
//    byte, read byte). Commands that arrive while a sequence runs are ignored.
//  - Response channel (rsp_*): exactly one transaction per request: the line
//    drive after that tick, busy/done, ACK seen, last received byte, bus error.
//  - CSR port (csr_*): write-only. Index 0 is the half-period in ticks,
//    index 1 the clock stretch limit in ticks; zero acts as one. Write only
//    while no sequence is running.
//  - Latency: a response appears in the cycle after its request is taken.
//    Throughput: one transaction per cycle unless stalled, set by the single
//    registered sequencer step between request and response register.
//  - Stall: while rsp_stall holds a waiting response, req_stall is raised and
//    the sequencer state is frozen; taking the response frees the input in
//    the same cycle.
//  - Reset: both lines released, sequencer idle, flags and received byte
//    cleared, registers back to half-period 5 and stretch limit 10000.
`default_nettype none
module i2c_bit_level_master_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_send_nack,
   input  wire logic        req_scl_in,
   input  wire logic        req_sda_in,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_pull_low,
   output logic             rsp_sda_pull_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_ack_seen,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_bus_error,

   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]           half_period_ff;
   logic [15:0]           stretch_limit_ff;
   logic                  rsp_valid_ff;
   i2cbm_pkg::result_type rsp_data_ff;
   i2cbm_pkg::result_type step_result;
   logic                  req_take;

   // input is free when the result register is empty or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= i2cbm_pkg::HALF_PERIOD_RESET;
         stretch_limit_ff <= i2cbm_pkg::STRETCH_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            i2cbm_pkg::CSR_HALF_PERIOD:   half_period_ff   <= csr_wdata;
            i2cbm_pkg::CSR_STRETCH_LIMIT: stretch_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   i2cbm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .advance       (req_take),
      .kind          (req_kind),
      .tx_byte       (req_tx_byte),
      .send_nack     (req_send_nack),
      .scl_in        (req_scl_in),
      .sda_in        (req_sda_in),
      .half_period   (half_period_ff),
      .stretch_limit (stretch_limit_ff),
      .result        (step_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_pull_low = rsp_data_ff.scl_pull_low;
   assign rsp_sda_pull_low = rsp_data_ff.sda_pull_low;
   assign rsp_busy_res     = rsp_data_ff.busy_res;
   assign rsp_done_res     = rsp_data_ff.done_res;
   assign rsp_ack_seen     = rsp_data_ff.ack_seen;
   assign rsp_rx_byte      = rsp_data_ff.rx_byte;
   assign rsp_bus_error    = rsp_data_ff.bus_error;

`ifndef NO_ASSERTIONS
   a_take_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");
`endif

endmodule
`default_nettype wire

FILE: bench/i2cbm_result_checker.sv
// Checker for the I2C master bit engine: tick-level predictor and response scoreboard.
module i2cbm_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_send_nack,
   input  wire logic        req_scl_in,
   input  wire logic        req_sda_in,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_scl_pull_low,
   input  wire logic        rsp_sda_pull_low,
   input  wire logic        rsp_busy_res,
   input  wire logic        rsp_done_res,
   input  wire logic        rsp_ack_seen,
   input  wire logic [7:0]  rsp_rx_byte,
   input  wire logic        rsp_bus_error,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               error_count,
   output int               outstanding
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_S_D1 = 5'd1;
   localparam logic [4:0] ST_S_W  = 5'd2;
   localparam logic [4:0] ST_S_D2 = 5'd3;
   localparam logic [4:0] ST_S_D3 = 5'd4;
   localparam logic [4:0] ST_P_D1 = 5'd5;
   localparam logic [4:0] ST_P_D2 = 5'd6;
   localparam logic [4:0] ST_P_W  = 5'd7;
   localparam logic [4:0] ST_P_D3 = 5'd8;
   localparam logic [4:0] ST_P_D4 = 5'd9;
   localparam logic [4:0] ST_W_D0 = 5'd10;
   localparam logic [4:0] ST_W_DL = 5'd11;
   localparam logic [4:0] ST_W_W  = 5'd12;
   localparam logic [4:0] ST_W_DH = 5'd13;
   localparam logic [4:0] ST_A_DL = 5'd14;
   localparam logic [4:0] ST_A_W  = 5'd15;
   localparam logic [4:0] ST_A_DH = 5'd16;
   localparam logic [4:0] ST_A_DS = 5'd17;
   localparam logic [4:0] ST_R_D0 = 5'd18;
   localparam logic [4:0] ST_R_DL = 5'd19;
   localparam logic [4:0] ST_R_W  = 5'd20;
   localparam logic [4:0] ST_R_DH = 5'd21;
   localparam logic [4:0] ST_K_D1 = 5'd22;
   localparam logic [4:0] ST_K_D2 = 5'd23;
   localparam logic [4:0] ST_K_W  = 5'd24;
   localparam logic [4:0] ST_K_DH = 5'd25;

   typedef enum logic [1:0] {CLK_WAITING, CLK_HIGH, CLK_TIMEOUT} clock_wait_type;

   logic [4:0]  seq_state;
   logic [3:0]  bit_cnt;
   logic [7:0]  shift_byte;
   logic [15:0] delay_cnt;
   logic [15:0] stretch_cnt;
   logic        drive_scl;
   logic        drive_sda;
   logic        flag_ack;
   logic        flag_err;
   logic        flag_nack;
   logic [7:0]  rx_hold;
   logic [15:0] half_period;
   logic [15:0] stretch_limit;

   i2cbm_pkg::result_type pending_results[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic void clear_engine();
      seq_state     = ST_IDLE;
      bit_cnt       = '0;
      shift_byte    = '0;
      delay_cnt     = '0;
      stretch_cnt   = '0;
      drive_scl     = 1'b0;
      drive_sda     = 1'b0;
      flag_ack      = 1'b0;
      flag_err      = 1'b0;
      flag_nack     = 1'b0;
      rx_hold       = '0;
      half_period   = i2cbm_pkg::HALF_PERIOD_RESET;
      stretch_limit = i2cbm_pkg::STRETCH_LIMIT_RESET;
   endfunction

   // zero period acts as one
   function automatic logic delay_expired();
      logic [15:0] period;
      period = (half_period == 16'd0) ? 16'd1 : half_period;
      delay_cnt = delay_cnt + 16'd1;
      if (delay_cnt >= period) begin
         delay_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic clock_wait_type clock_check(input logic scl);
      logic [15:0] lim;
      lim = (stretch_limit == 16'd0) ? 16'd1 : stretch_limit;
      if (scl) begin
         stretch_cnt = '0;
         return CLK_HIGH;
      end
      stretch_cnt = stretch_cnt + 16'd1;
      if (stretch_cnt >= lim) begin
         stretch_cnt = '0;
         return CLK_TIMEOUT;
      end
      return CLK_WAITING;
   endfunction

   function automatic void release_clock(input logic [4:0] follow);
      drive_scl   = 1'b0;
      stretch_cnt = '0;
      seq_state   = follow;
   endfunction

   function automatic void drive_data_bit();
      drive_scl = 1'b1;
      drive_sda = !shift_byte[bit_cnt[2:0]];
   endfunction

   // stretch timeout outside a stop restarts as a stop sequence
   function automatic void await_clock(input logic scl, input logic [4:0] follow);
      clock_wait_type res;
      res = clock_check(scl);
      if (res == CLK_HIGH) begin
         seq_state = follow;
      end else if (res == CLK_TIMEOUT) begin
         flag_err  = 1'b1;
         seq_state = ST_P_D1;
         delay_cnt = '0;
      end
   endfunction

   function automatic i2cbm_pkg::result_type predict_tick(input logic [2:0] kind,
                                                          input logic [7:0] tx,
                                                          input logic nack,
                                                          input logic scl,
                                                          input logic sda);
      logic                  finished;
      clock_wait_type        res;
      i2cbm_pkg::result_type r;
      finished = 1'b0;
      if (seq_state == ST_IDLE) begin
         if (kind inside {i2cbm_pkg::KIND_START, i2cbm_pkg::KIND_STOP,
                          i2cbm_pkg::KIND_WRITE, i2cbm_pkg::KIND_READ}) begin
            flag_err    = 1'b0;
            flag_nack   = 1'b0;
            delay_cnt   = '0;
            stretch_cnt = '0;
            case (kind)
               i2cbm_pkg::KIND_START: begin
                  drive_sda = 1'b0;
                  seq_state = ST_S_D1;
               end
               i2cbm_pkg::KIND_STOP: seq_state = ST_P_D1;
               i2cbm_pkg::KIND_WRITE: begin
                  shift_byte = tx;
                  flag_ack   = 1'b0;
                  seq_state  = ST_W_D0;
               end
               default: begin
                  shift_byte = '0;
                  if (nack) flag_nack = 1'b1;
                  seq_state = ST_R_D0;
               end
            endcase
         end
      end else begin
         case (seq_state)
            ST_S_D1: if (delay_expired()) release_clock(ST_S_W);
            ST_S_W:  await_clock(scl, ST_S_D2);
            ST_S_D2: if (delay_expired()) begin
               drive_sda = 1'b1;
               seq_state = ST_S_D3;
            end
            ST_S_D3: if (delay_expired()) finished = 1'b1;
            ST_P_D1: if (delay_expired()) begin
               drive_sda = 1'b1;
               seq_state = ST_P_D2;
            end
            ST_P_D2: if (delay_expired()) release_clock(ST_P_W);
            ST_P_W: begin
               // a timeout inside a stop only flags the error
               res = clock_check(scl);
               if (res == CLK_TIMEOUT) flag_err = 1'b1;
               if (res != CLK_WAITING) seq_state = ST_P_D3;
            end
            ST_P_D3: if (delay_expired()) begin
               drive_sda = 1'b0;
               seq_state = ST_P_D4;
            end
            ST_P_D4: if (delay_expired()) finished = 1'b1;
            ST_W_D0: if (delay_expired()) begin
               bit_cnt = 4'd7;
               drive_data_bit();
               seq_state = ST_W_DL;
            end
            ST_W_DL: if (delay_expired()) release_clock(ST_W_W);
            ST_W_W:  await_clock(scl, ST_W_DH);
            ST_W_DH: if (delay_expired()) begin
               if (bit_cnt != 4'd0) begin
                  bit_cnt = bit_cnt - 4'd1;
                  drive_data_bit();
                  seq_state = ST_W_DL;
               end else begin
                  drive_scl = 1'b1;
                  drive_sda = 1'b0;
                  seq_state = ST_A_DL;
               end
            end
            ST_A_DL: if (delay_expired()) release_clock(ST_A_W);
            ST_A_W:  await_clock(scl, ST_A_DH);
            ST_A_DH: if (delay_expired()) begin
               flag_ack  = !sda;
               seq_state = ST_A_DS;
            end
            ST_A_DS: if (delay_expired()) begin
               drive_scl = 1'b1;
               finished  = 1'b1;
            end
            ST_R_D0: if (delay_expired()) begin
               bit_cnt   = 4'd8;
               drive_scl = 1'b1;
               seq_state = ST_R_DL;
            end
            ST_R_DL: if (delay_expired()) release_clock(ST_R_W);
            ST_R_W:  await_clock(scl, ST_R_DH);
            ST_R_DH: if (delay_expired()) begin
               shift_byte = {shift_byte[6:0], sda};
               bit_cnt    = bit_cnt - 4'd1;
               drive_scl  = 1'b1;
               if (bit_cnt == 4'd0) begin
                  rx_hold   = shift_byte;
                  seq_state = ST_K_D1;
               end else begin
                  seq_state = ST_R_DL;
               end
            end
            ST_K_D1: if (delay_expired()) begin
               if (!flag_nack) drive_sda = 1'b1;
               seq_state = ST_K_D2;
            end
            ST_K_D2: if (delay_expired()) release_clock(ST_K_W);
            ST_K_W:  await_clock(scl, ST_K_DH);
            ST_K_DH: if (delay_expired()) begin
               drive_scl = 1'b1;
               drive_sda = 1'b0;
               finished  = 1'b1;
            end
            default: seq_state = ST_IDLE;
         endcase
         if (finished) begin
            seq_state   = ST_IDLE;
            delay_cnt   = '0;
            stretch_cnt = '0;
         end
      end
      r.scl_pull_low = drive_scl;
      r.sda_pull_low = drive_sda;
      r.busy_res     = (seq_state != ST_IDLE);
      r.done_res     = finished;
      r.ack_seen     = flag_ack;
      r.rx_byte      = rx_hold;
      r.bus_error    = flag_err;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, seen);
         error_count = error_count + 1;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      i2cbm_pkg::result_type want;
      if (reset) begin
         clear_engine();
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with nothing pending");
               error_count = error_count + 1;
            end else begin
               want = pending_results.pop_front();
               check_field("scl_pull_low", 8'(want.scl_pull_low), 8'(rsp_scl_pull_low));
               check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(rsp_sda_pull_low));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               check_field("ack_seen", 8'(want.ack_seen), 8'(rsp_ack_seen));
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("bus_error", 8'(want.bus_error), 8'(rsp_bus_error));
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(predict_tick(req_kind, req_tx_byte, req_send_nack,
                                                   req_scl_in, req_sda_in));
         // register writes apply from the following tick on
         if (csr_wr_en) begin
            if (csr_index == i2cbm_pkg::CSR_HALF_PERIOD) half_period = csr_wdata;
            else stretch_limit = csr_wdata;
         end
      end
      outstanding = pending_results.size();
   end

endmodule

FILE: bench/i2c_bit_level_master_core_tb.sv
// Testbench top for the I2C master bit engine: bus-aware stimulus, idling and verdict.
module i2c_bit_level_master_core_tb;

   // kinds above read are undefined and must act as a plain tick
   localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
   localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

   localparam int CYCLE_LIMIT = 20_000;

   // how the emulated slave answers on SDA when the master releases it
   typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} slave_sda_type;

   logic           clock         = 1'b0;
   logic           reset         = 1'b1;
   logic           req_valid     = 1'b0;
   logic           req_stall;
   logic [2:0]     req_kind      = i2cbm_pkg::KIND_TICK;
   logic [7:0]     req_tx_byte   = 8'h00;
   logic           req_send_nack = 1'b0;
   logic           req_scl_in    = 1'b1;
   logic           req_sda_in    = 1'b1;
   logic           rsp_valid;
   logic           rsp_stall     = 1'b0;
   logic           rsp_scl_pull_low;
   logic           rsp_sda_pull_low;
   logic           rsp_busy_res;
   logic           rsp_done_res;
   logic           rsp_ack_seen;
   logic [7:0]     rsp_rx_byte;
   logic           rsp_bus_error;
   logic           csr_wr_en     = 1'b0;
   logic           csr_index     = i2cbm_pkg::CSR_HALF_PERIOD;
   logic [15:0]    csr_wdata     = 16'h0000;

   int             error_count;
   int             bus_pending;
   int             cycle_count   = 0;

   // stimulus knobs
   bit             gaps_on       = 1'b1;
   bit             stall_on      = 1'b1;
   bit             stretch_en    = 1'b0;
   bit             scl_hold_low  = 1'b0;
   int             stretch_left  = 0;
   slave_sda_type  slave_sda     = SDA_RANDOM;

   // line drive and busy of the newest response already taken
   logic           seen_scl_low  = 1'b0;
   logic           seen_sda_low  = 1'b0;
   logic           seen_busy     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   i2c_bit_level_master_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_tx_byte      (req_tx_byte),
      .req_send_nack    (req_send_nack),
      .req_scl_in       (req_scl_in),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_pull_low (rsp_scl_pull_low),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_seen     (rsp_ack_seen),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_bus_error    (rsp_bus_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   i2cbm_result_checker bus_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_tx_byte      (req_tx_byte),
      .req_send_nack    (req_send_nack),
      .req_scl_in       (req_scl_in),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_pull_low (rsp_scl_pull_low),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_seen     (rsp_ack_seen),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_bus_error    (rsp_bus_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .outstanding      (bus_pending)
   );

   // random backpressure on the response side, independent of the request side
   always @(negedge clock)
      rsp_stall <= stall_on && ($urandom_range(99) < 6);

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         seen_scl_low <= rsp_scl_pull_low;
         seen_sda_low <= rsp_sda_pull_low;
         seen_busy    <= rsp_busy_res;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // At a falling edge the newest response is the one on the port if valid
   // (each response is registered from its request, and a held response stalls the request side);
   // otherwise it is the last one taken.
   function automatic logic block_busy();
      return rsp_valid ? rsp_busy_res : seen_busy;
   endfunction

   // One tick transaction. SCL and SDA are derived from the master's current
   // drive, like a wired-AND bus: a pulled line reads low, a released SCL may
   // be stretched by the slave, a released SDA carries the slave's bit.
   task automatic put_tick(input logic [2:0] kind, input logic [7:0] tx, input logic nack);
      logic scl_low;
      logic sda_low;
      logic scl_level;
      logic sda_level;
      while (gaps_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      scl_low = rsp_valid ? rsp_scl_pull_low : seen_scl_low;
      sda_low = rsp_valid ? rsp_sda_pull_low : seen_sda_low;
      if (scl_low) begin
         scl_level = 1'b0;
         // arm a clock stretch for the next release
         if (stretch_en && stretch_left == 0 && $urandom_range(99) < 4)
            stretch_left = $urandom_range(4, 1);
      end else if (stretch_left != 0) begin
         scl_level = 1'b0;
         stretch_left = stretch_left - 1;
      end else begin
         scl_level = !scl_hold_low;
      end
      case (slave_sda)
         SDA_LOW:  sda_level = 1'b0;
         SDA_HIGH: sda_level = 1'b1;
         default:  sda_level = 1'($urandom_range(1));
      endcase
      if (sda_low) sda_level = 1'b0;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_tx_byte   <= tx;
      req_send_nack <= nack;
      req_scl_in    <= scl_level;
      req_sda_in    <= sda_level;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Tick until the running sequence is over, with stray commands mixed in
   // (ignored while busy), then let every response drain.
   task automatic run_to_idle();
      logic [2:0] kind;
      while (block_busy()) begin
         kind = ($urandom_range(9) == 0)
                ? 3'($urandom_range(KIND_RSVD_LAST, i2cbm_pkg::KIND_START))
                : i2cbm_pkg::KIND_TICK;
         put_tick(kind, 8'($urandom), 1'($urandom));
      end
      req_valid <= 1'b0;
      do @(negedge clock); while (bus_pending != 0);
   endtask

   task automatic do_command(input logic [2:0] kind, input logic [7:0] tx, input logic nack);
      put_tick(kind, tx, nack);
      run_to_idle();
   endtask

   // only called with the engine idle and the request side quiet
   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed frames (start, writes/reads, stop) with random data,
   // plus plain ticks, reserved kinds, out-of-frame commands and commands
   // thrown at a busy engine.
   task automatic random_traffic(input int count, input bit with_pause);
      logic [2:0] kind;
      int         pick;
      bit         in_frame;
      in_frame = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (with_pause && i == count / 2) begin
            // hold off until everything sent so far has come back
            req_valid <= 1'b0;
            do @(negedge clock); while (bus_pending != 0);
         end
         pick = $urandom_range(99);
         if (block_busy())
            kind = (pick < 10)
                   ? 3'($urandom_range(KIND_RSVD_LAST, i2cbm_pkg::KIND_START))
                   : i2cbm_pkg::KIND_TICK;
         else if (pick < 8)
            kind = i2cbm_pkg::KIND_TICK;
         else if (pick < 12)
            kind = 3'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST));
         else if (!in_frame)
            kind = (pick < 20)
                   ? 3'($urandom_range(i2cbm_pkg::KIND_READ, i2cbm_pkg::KIND_STOP))
                   : i2cbm_pkg::KIND_START;
         else if (pick < 30)
            kind = i2cbm_pkg::KIND_STOP;
         else if (pick < 65)
            kind = i2cbm_pkg::KIND_WRITE;
         else
            kind = i2cbm_pkg::KIND_READ;
         if (!block_busy()) begin
            if (kind == i2cbm_pkg::KIND_START) in_frame = 1'b1;
            else if (kind == i2cbm_pkg::KIND_STOP) in_frame = 1'b0;
         end
         put_tick(kind, 8'($urandom), 1'($urandom));
      end
      run_to_idle();
   endtask

   initial begin
      // reset held, then released at a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, reset register values (half-period 5, limit 10000) ---
      put_tick(i2cbm_pkg::KIND_TICK, 8'h00, 1'b0);
      for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
         put_tick(3'(k), 8'hFF, 1'b1);
      slave_sda = SDA_LOW;
      do_command(i2cbm_pkg::KIND_START, 8'h00, 1'b0);
      do_command(i2cbm_pkg::KIND_WRITE, 8'h00, 1'b0);   // all-zero byte, slave ACKs
      slave_sda = SDA_HIGH;
      do_command(i2cbm_pkg::KIND_READ, 8'h00, 1'b0);    // reads 0xFF, master ACKs
      slave_sda = SDA_RANDOM;
      do_command(i2cbm_pkg::KIND_STOP, 8'h00, 1'b0);

      // --- zero in both registers acts as one ---
      write_csr(i2cbm_pkg::CSR_HALF_PERIOD, 16'd0);
      write_csr(i2cbm_pkg::CSR_STRETCH_LIMIT, 16'd0);
      do_command(i2cbm_pkg::KIND_START, 8'h00, 1'b0);
      slave_sda = SDA_HIGH;
      do_command(i2cbm_pkg::KIND_WRITE, 8'hFF, 1'b1);   // all-ones byte, slave NACKs
      slave_sda = SDA_LOW;
      do_command(i2cbm_pkg::KIND_READ, 8'hFF, 1'b1);    // reads 0x00, master NACKs
      slave_sda = SDA_RANDOM;
      // slave holds SCL low: timeout in a write forces a stop,
      // whose own clock wait then times out too
      scl_hold_low = 1'b1;
      do_command(i2cbm_pkg::KIND_WRITE, 8'h3C, 1'b0);
      scl_hold_low = 1'b0;

      // --- shortest half-period and stretch limit ---
      write_csr(i2cbm_pkg::CSR_HALF_PERIOD, 16'd1);
      write_csr(i2cbm_pkg::CSR_STRETCH_LIMIT, 16'd1);
      do_command(i2cbm_pkg::KIND_START, 8'h00, 1'b0);
      scl_hold_low = 1'b1;
      do_command(i2cbm_pkg::KIND_READ, 8'h00, 1'b0);    // read cut short keeps the old byte
      do_command(i2cbm_pkg::KIND_STOP, 8'h00, 1'b0);    // timeout inside a stop
      scl_hold_low = 1'b0;
      do_command(i2cbm_pkg::KIND_START, 8'h00, 1'b0);
      do_command(i2cbm_pkg::KIND_WRITE, 8'h5A, 1'b0);
      do_command(i2cbm_pkg::KIND_WRITE, 8'hA5, 1'b1);
      stretch_en = 1'b1;
      random_traffic(40, 1'b0);

      // --- moderate timing, with a full drain mid-run ---
      write_csr(i2cbm_pkg::CSR_HALF_PERIOD, 16'd2);
      write_csr(i2cbm_pkg::CSR_STRETCH_LIMIT, 16'd3);
      random_traffic(40, 1'b1);

      // --- longest stretch limit, no idling on either side ---
      write_csr(i2cbm_pkg::CSR_HALF_PERIOD, 16'd1);
      write_csr(i2cbm_pkg::CSR_STRETCH_LIMIT, 16'hFFFF);
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      random_traffic(80, 1'b0);
      gaps_on  = 1'b1;
      stall_on = 1'b1;

      // --- slow clock, tight limit so stretches often time out ---
      write_csr(i2cbm_pkg::CSR_HALF_PERIOD, 16'd7);
      write_csr(i2cbm_pkg::CSR_STRETCH_LIMIT, 16'd2);
      random_traffic(40, 1'b0);

      // wait before the verdict so that any stray response is caught
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
